>>> sv/ec_point_add_double_scalar_mult_defines.svh
// Assertion macros used by the port-level checker file.
`ifndef EC_POINT_ADD_DOUBLE_SCALAR_MULT_DEFINES_SVH
`define EC_POINT_ADD_DOUBLE_SCALAR_MULT_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define ECP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define ECP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> sv/ecp_pkg.sv
// Package with widths, commands and state types for the point arithmetic block.
package ecp_pkg;
  localparam int unsigned FieldBitsDef = 16;
  localparam int unsigned CountBitsDef = 16;
  localparam int unsigned OutBits      = 16;
  localparam int unsigned CfgIdxBits   = 1;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_DBL = 2'd1,
    CMD_MUL = 2'd2,
    CMD_NOP = 2'd3
  } cmd_e;

  typedef enum logic [0:0] {
    REG_PRIME = 1'b0,
    REG_A     = 1'b1
  } reg_e;

  typedef enum logic [2:0] {
    AU_IDLE,
    AU_RED,
    AU_MUL,
    AU_DIV,
    AU_DONE
  } au_state_e;

  typedef enum logic [1:0] {
    AU_OP_RED = 2'd0,
    AU_OP_MUL = 2'd1,
    AU_OP_INV = 2'd2
  } au_op_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RA, S_RPX, S_RPY, S_RQX, S_RQY,
    S_DISPATCH,
    S_ADD_START, S_ADD_INV, S_ADD_LAM,
    S_DBL_START, S_DBL_INV, S_DBL_X2, S_DBL_X3, S_DBL_LAM,
    S_SL_L2, S_SL_Y,
    S_STEP,
    S_OUT
  } seq_state_e;
endpackage

>>> sv/ecp_arith.sv
// Bit-serial modular unit: reduction, multiplication and inversion modulo p.
module ecp_arith import ecp_pkg::*; #(
  parameter int unsigned FieldBits = FieldBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  au_op_e               op_i,
  input  logic [FieldBits-1:0] a_i,
  input  logic [FieldBits-1:0] b_i,
  input  logic [FieldBits-1:0] p_i,
  output logic                 done_o,
  output logic                 ok_o,
  output logic [FieldBits-1:0] res_o
);
  localparam int unsigned CntBits = $clog2(FieldBits + 1);

  au_state_e state_q, state_d;
  au_op_e op_q, op_d;
  logic [FieldBits-1:0] a_q, a_d, b_q, b_d, r_q, r_d;
  logic [FieldBits-1:0] r0_q, r0_d, r1_q, r1_d, t0_q, t0_d, t1_q, t1_d;
  logic [FieldBits-1:0] quo_q, quo_d, rem_q, rem_d;
  logic [CntBits-1:0]   cnt_q, cnt_d;
  logic                 ok_q, ok_d, inner_q, inner_d;
  logic [FieldBits:0]   rem_sh, sum_w, dbl_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= AU_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; a_q <= a_d; b_q <= b_d; r_q <= r_d;
    r0_q <= r0_d; r1_q <= r1_d; t0_q <= t0_d; t1_q <= t1_d;
    quo_q <= quo_d; rem_q <= rem_d; cnt_q <= cnt_d; ok_q <= ok_d;
    inner_q <= inner_d;
  end

  always_comb begin
    state_d = state_q; op_d = op_q; a_d = a_q; b_d = b_q; r_d = r_q;
    r0_d = r0_q; r1_d = r1_q; t0_d = t0_q; t1_d = t1_q;
    quo_d = quo_q; rem_d = rem_q; cnt_d = cnt_q; ok_d = ok_q; inner_d = inner_q;
    rem_sh = '0; sum_w = '0; dbl_w = '0;
    unique case (state_q)
      AU_IDLE, AU_DONE: begin
        state_d = AU_IDLE;
        if (start_i) begin
          op_d = op_i; a_d = a_i; b_d = b_i; r_d = '0; rem_d = '0; quo_d = '0;
          cnt_d = CntBits'(FieldBits); ok_d = 1'b1; inner_d = 1'b0;
          r0_d = p_i; t0_d = '0; t1_d = FieldBits'(1);
          unique case (op_i)
            AU_OP_MUL: state_d = AU_MUL;
            AU_OP_INV: begin
              op_d = AU_OP_RED; state_d = AU_RED;
            end
            default: state_d = AU_RED;
          endcase
          if (op_i == AU_OP_INV) begin
            op_d = AU_OP_INV;
          end
        end
      end
      AU_RED: begin
        // Restoring long division, one quotient bit a cycle.
        rem_sh = {rem_q, a_q[FieldBits-1]};
        a_d = {a_q[FieldBits-2:0], 1'b0};
        if (rem_sh >= {1'b0, p_i}) begin
          rem_d = FieldBits'(rem_sh - {1'b0, p_i});
        end else begin
          rem_d = rem_sh[FieldBits-1:0];
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CntBits'(1)) begin
          if (op_q == AU_OP_INV) begin
            r1_d = rem_d;
            state_d = AU_DIV;
          end else begin
            r_d = rem_d;
            state_d = AU_DONE;
          end
        end
      end
      AU_MUL: begin
        // Shift and add, multiplicand doubled mod p each cycle.
        if (b_q[0]) begin
          sum_w = {1'b0, r_q} + {1'b0, a_q};
          r_d = (sum_w >= {1'b0, p_i}) ? FieldBits'(sum_w - {1'b0, p_i})
                                       : sum_w[FieldBits-1:0];
        end
        dbl_w = {a_q, 1'b0};
        a_d = (dbl_w >= {1'b0, p_i}) ? FieldBits'(dbl_w - {1'b0, p_i})
                                     : dbl_w[FieldBits-1:0];
        b_d = b_q >> 1;
        if (b_d == '0) begin
          if (inner_q) begin
            sum_w = {1'b0, t0_q} + {1'b0, p_i} - {1'b0, r_d};
            t0_d = t1_q;
            t1_d = (sum_w >= {1'b0, p_i}) ? FieldBits'(sum_w - {1'b0, p_i})
                                          : sum_w[FieldBits-1:0];
            r0_d = r1_q; r1_d = rem_q;
            inner_d = 1'b0;
            state_d = AU_DIV;
          end else begin
            state_d = AU_DONE;
          end
        end
      end
      AU_DIV: begin
        if (!inner_q) begin
          if (r1_q == '0) begin
            ok_d = (r0_q == FieldBits'(1));
            r_d = t0_q;
            state_d = AU_DONE;
          end else begin
            a_d = r0_q; rem_d = '0; quo_d = '0;
            cnt_d = CntBits'(FieldBits); inner_d = 1'b1;
          end
        end else begin
          // Quotient and remainder of r0 / r1, one bit a cycle.
          rem_sh = {rem_q, a_q[FieldBits-1]};
          a_d = {a_q[FieldBits-2:0], 1'b0};
          if (rem_sh >= {1'b0, r1_q}) begin
            rem_d = FieldBits'(rem_sh - {1'b0, r1_q});
            quo_d = {quo_q[FieldBits-2:0], 1'b1};
          end else begin
            rem_d = rem_sh[FieldBits-1:0];
            quo_d = {quo_q[FieldBits-2:0], 1'b0};
          end
          cnt_d = cnt_q - 1'b1;
          if (cnt_q == CntBits'(1)) begin
            // The serial multiply reduces the quotient mod p as it goes.
            a_d = t1_q; b_d = quo_d; r_d = '0;
            if (quo_d == '0) begin
              sum_w = {1'b0, t0_q};
              t0_d = t1_q; t1_d = t0_q;
              r0_d = r1_q; r1_d = rem_d; inner_d = 1'b0;
            end else begin
              state_d = AU_MUL;
            end
          end
        end
      end
      default: state_d = AU_IDLE;
    endcase
  end

  assign done_o = (state_q == AU_DONE);
  assign ok_o   = ok_q;
  assign res_o  = r_q;
endmodule

>>> sv/ecp_seq.sv
// Sequencer that drives the modular unit through add, double and scalar loops.
module ecp_seq import ecp_pkg::*; #(
  parameter int unsigned FieldBits = FieldBitsDef,
  parameter int unsigned CountBits = CountBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 go_i,
  input  cmd_e                 cmd_i,
  input  logic [FieldBits-1:0] px_i,
  input  logic [FieldBits-1:0] py_i,
  input  logic [FieldBits-1:0] qx_i,
  input  logic [FieldBits-1:0] qy_i,
  input  logic [CountBits-1:0] scalar_i,
  input  logic [FieldBits-1:0] prime_i,
  input  logic [FieldBits-1:0] ca_raw_i,
  input  logic                 out_free_i,
  output logic                 busy_o,
  output logic                 res_valid_o,
  output logic [FieldBits-1:0] rx_o,
  output logic [FieldBits-1:0] ry_o,
  output logic                 inf_o,
  output logic [CountBits-1:0] mult_o
);
  seq_state_e state_q, state_d;
  cmd_e cmd_q, cmd_d;
  logic [FieldBits-1:0] p_q, p_d, ca_q, ca_d, px_q, px_d, py_q, py_d;
  logic [FieldBits-1:0] qx_q, qx_d, qy_q, qy_d, rx_q, rx_d, ry_q, ry_d;
  logic [FieldBits-1:0] lam_q, lam_d, x1_q, x1_d, y1_q, y1_d, x2_q, x2_d;
  logic [FieldBits-1:0] tmp_q, tmp_d;
  logic [CountBits-1:0] m_q, m_d, mult_q, mult_d;
  logic                 inf_q, inf_d;
  logic                 au_start;
  au_op_e               au_op;
  logic [FieldBits-1:0] au_a, au_b, au_res;
  logic                 au_done, au_ok;

  ecp_arith #(.FieldBits(FieldBits)) u_arith (
    .clk_i, .rst_ni, .start_i(au_start), .op_i(au_op), .a_i(au_a), .b_i(au_b),
    .p_i(p_q), .done_o(au_done), .ok_o(au_ok), .res_o(au_res)
  );

  function automatic logic [FieldBits-1:0] msub(logic [FieldBits-1:0] a,
      logic [FieldBits-1:0] b, logic [FieldBits-1:0] p);
    return (a >= b) ? a - b : p - (b - a);
  endfunction

  function automatic logic [FieldBits-1:0] madd(logic [FieldBits-1:0] a,
      logic [FieldBits-1:0] b, logic [FieldBits-1:0] p);
    return (a >= p - b) ? a - (p - b) : a + b;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; p_q <= p_d; ca_q <= ca_d; px_q <= px_d; py_q <= py_d;
    qx_q <= qx_d; qy_q <= qy_d; rx_q <= rx_d; ry_q <= ry_d; lam_q <= lam_d;
    x1_q <= x1_d; y1_q <= y1_d; x2_q <= x2_d; tmp_q <= tmp_d;
    m_q <= m_d; mult_q <= mult_d; inf_q <= inf_d;
  end

  always_comb begin
    state_d = state_q; cmd_d = cmd_q; p_d = p_q; ca_d = ca_q; px_d = px_q;
    py_d = py_q; qx_d = qx_q; qy_d = qy_q; rx_d = rx_q; ry_d = ry_q;
    lam_d = lam_q; x1_d = x1_q; y1_d = y1_q; x2_d = x2_q; tmp_d = tmp_q;
    m_d = m_q; mult_d = mult_q; inf_d = inf_q;
    au_start = 1'b0; au_op = AU_OP_RED; au_a = '0; au_b = '0;
    unique case (state_q)
      S_IDLE: begin
        if (go_i) begin
          cmd_d = cmd_i;
          p_d = (prime_i < FieldBits'(3)) ? FieldBits'(3) : prime_i;
          px_d = px_i; py_d = py_i; qx_d = qx_i; qy_d = qy_i;
          m_d = (scalar_i < CountBits'(2)) ? CountBits'(2) : scalar_i;
          au_start = 1'b1; au_a = ca_raw_i;
          state_d = S_RA;
        end
      end
      S_RA: if (au_done) begin
        ca_d = au_res; au_start = 1'b1; au_a = px_q; state_d = S_RPX;
      end
      S_RPX: if (au_done) begin
        px_d = au_res; au_start = 1'b1; au_a = py_q; state_d = S_RPY;
      end
      S_RPY: if (au_done) begin
        py_d = au_res; au_start = 1'b1; au_a = qx_q; state_d = S_RQX;
      end
      S_RQX: if (au_done) begin
        qx_d = au_res; au_start = 1'b1; au_a = qy_q; state_d = S_RQY;
      end
      S_RQY: if (au_done) begin
        qy_d = au_res; state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        unique case (cmd_q)
          CMD_ADD: begin
            mult_d = CountBits'(1);
            rx_d = px_q; ry_d = py_q; state_d = S_ADD_START;
          end
          CMD_DBL, CMD_MUL: begin
            mult_d = CountBits'(2);
            rx_d = px_q; ry_d = py_q; state_d = S_DBL_START;
          end
          default: begin
            rx_d = '0; ry_d = '0; inf_d = 1'b1; mult_d = '0; state_d = S_OUT;
          end
        endcase
      end
      // Add P (px,py) to the running point (rx,ry); for add Q sits in rx,ry.
      S_ADD_START: begin
        if (cmd_q == CMD_ADD) begin
          rx_d = qx_q; ry_d = qy_q;
        end
        x1_d = px_q; y1_d = py_q;
        x2_d = (cmd_q == CMD_ADD) ? qx_q : rx_q;
        tmp_d = (cmd_q == CMD_ADD) ? qy_q : ry_q;
        if (((cmd_q == CMD_ADD) ? qx_q : rx_q) == px_q) begin
          if (((cmd_q == CMD_ADD) ? qy_q : ry_q) == py_q) begin
            rx_d = px_q; ry_d = py_q; state_d = S_DBL_START;
          end else begin
            inf_d = 1'b1; state_d = S_STEP;
          end
        end else begin
          au_start = 1'b1; au_op = AU_OP_INV;
          au_a = msub((cmd_q == CMD_ADD) ? qx_q : rx_q, px_q, p_q);
          state_d = S_ADD_INV;
        end
      end
      S_ADD_INV: if (au_done) begin
        if (!au_ok) begin
          inf_d = 1'b1; state_d = S_STEP;
        end else begin
          au_start = 1'b1; au_op = AU_OP_MUL;
          au_a = msub(tmp_q, y1_q, p_q); au_b = au_res;
          state_d = S_ADD_LAM;
        end
      end
      S_ADD_LAM: if (au_done) begin
        lam_d = au_res; au_start = 1'b1; au_op = AU_OP_MUL;
        au_a = au_res; au_b = au_res; state_d = S_SL_L2;
      end
      S_DBL_START: begin
        x1_d = rx_q; y1_d = ry_q; x2_d = rx_q;
        if (ry_q == '0) begin
          inf_d = 1'b1; state_d = S_STEP;
        end else begin
          au_start = 1'b1; au_op = AU_OP_INV; au_a = madd(ry_q, ry_q, p_q);
          state_d = S_DBL_INV;
        end
      end
      S_DBL_INV: if (au_done) begin
        if (!au_ok) begin
          inf_d = 1'b1; state_d = S_STEP;
        end else begin
          tmp_d = au_res; au_start = 1'b1; au_op = AU_OP_MUL;
          au_a = x1_q; au_b = x1_q; state_d = S_DBL_X2;
        end
      end
      S_DBL_X2: if (au_done) begin
        au_start = 1'b1; au_op = AU_OP_MUL;
        au_a = au_res; au_b = FieldBits'(3); state_d = S_DBL_X3;
      end
      S_DBL_X3: if (au_done) begin
        au_start = 1'b1; au_op = AU_OP_MUL;
        au_a = madd(au_res, ca_q, p_q); au_b = tmp_q; state_d = S_DBL_LAM;
      end
      S_DBL_LAM: if (au_done) begin
        lam_d = au_res; au_start = 1'b1; au_op = AU_OP_MUL;
        au_a = au_res; au_b = au_res; state_d = S_SL_L2;
      end
      S_SL_L2: if (au_done) begin
        rx_d = msub(msub(au_res, x1_q, p_q), x2_q, p_q);
        au_start = 1'b1; au_op = AU_OP_MUL; au_a = lam_q;
        au_b = msub(x1_q, rx_d, p_q); state_d = S_SL_Y;
      end
      S_SL_Y: if (au_done) begin
        ry_d = msub(au_res, y1_q, p_q); state_d = S_STEP;
      end
      S_STEP: begin
        if (cmd_q == CMD_MUL && !inf_q && mult_q != m_q) begin
          mult_d = mult_q + 1'b1; state_d = S_ADD_START;
        end else begin
          if (inf_q) begin
            rx_d = '0; ry_d = '0;
          end
          state_d = S_OUT;
        end
      end
      S_OUT: if (out_free_i) begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    if (state_q == S_IDLE && go_i) begin
      inf_d = 1'b0;
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_OUT);
  assign rx_o = rx_q;
  assign ry_o = ry_q;
  assign inf_o = inf_q;
  assign mult_o = mult_q;
endmodule

>>> sv/ec_point_add_double_scalar_mult.sv
// Top level of the elliptic-curve point add, double and scalar multiply block.
// The slave channel takes one beat per command: cmd, P, Q and the scalar.
// The master channel returns one beat per command: the result point, an
// infinity flag and the multiple reached. Configuration writes set the field
// prime (index 0) and the curve coefficient a (index 1).
// Every modular multiply, reduction or quotient step runs bit-serially through
// one shared unit. An add or double is dominated by the extended Euclidean
// inversion; a scalar multiply by m takes about m-1 such point operations.
// One command is processed at a time; s_axis_tready is high only when idle.
// The result is moved into an output register, after which the next command
// can be accepted while that result beat still waits for the receiver; a
// stalled receiver then holds the following result, and the input, back.
// Reset clears the control state and loads p = 97 and a = 2.
module ec_point_add_double_scalar_mult import ecp_pkg::*; #(
  parameter int unsigned FieldBits = FieldBitsDef,
  parameter int unsigned CountBits = CountBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // cmd[1:0], px[17:2], py[33:18], qx[49:34], qy[65:50], scalar[81:66]
  input  logic [87:0]           s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // rx[15:0], ry[31:16], at_infinity[32], multiple_reached[48:33]
  output logic [55:0]           m_axis_tdata,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_idx_i,
  input  logic [15:0]           cfg_wdata_i
);
  logic [15:0] prime_q, ca_q;
  logic        out_v_q, busy, res_v, inf, go;
  logic [FieldBits-1:0] rx, ry;
  logic [CountBits-1:0] mult;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prime_q <= 16'd97;
      ca_q    <= 16'd2;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_PRIME: prime_q <= cfg_wdata_i;
        REG_A:     ca_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !busy;
  assign go = s_axis_tvalid && s_axis_tready;

  ecp_seq #(.FieldBits(FieldBits), .CountBits(CountBits)) u_seq (
    .clk_i, .rst_ni, .go_i(go), .cmd_i(cmd_e'(s_axis_tdata[1:0])),
    .px_i(FieldBits'(s_axis_tdata[17:2])), .py_i(FieldBits'(s_axis_tdata[33:18])),
    .qx_i(FieldBits'(s_axis_tdata[49:34])), .qy_i(FieldBits'(s_axis_tdata[65:50])),
    .scalar_i(CountBits'(s_axis_tdata[81:66])),
    .prime_i(FieldBits'(prime_q)), .ca_raw_i(FieldBits'(ca_q)),
    .out_free_i(!out_v_q || m_axis_tready),
    .busy_o(busy), .res_valid_o(res_v), .rx_o(rx), .ry_o(ry), .inf_o(inf),
    .mult_o(mult)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (res_v && (!out_v_q || m_axis_tready)) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_v && (!out_v_q || m_axis_tready)) begin
      m_axis_tdata <= {7'd0, 16'(mult), inf, 16'(ry), 16'(rx)};
    end
  end

  assign m_axis_tvalid = out_v_q;
endmodule

>>> sv/ecp_checker.sv
// Port-level checker for the point arithmetic block, bound to the top level.
`include "ec_point_add_double_scalar_mult_defines.svh"
module ecp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata
);
  `ECP_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result beat dropped while stalled")
  `ECP_ASSERT_NXT(a_busy_after_take, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second beat taken while working")
  `ECP_ASSERT_IMP(a_inf_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[32], m_axis_tdata[31:0] == 32'd0, "infinity result with non-zero coordinates")
endmodule

bind ec_point_add_double_scalar_mult ecp_checker u_ecp_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid,
  .m_axis_tready, .m_axis_tdata
);

>>> test/ec_point_add_double_scalar_mult_tb.sv
// Self-checking testbench for the elliptic-curve point add, double and scalar multiply block.
`timescale 1ns / 1ps

module ec_point_add_double_scalar_mult_tb;
  import ecp_pkg::*;

  localparam int unsigned CycleLimit = 4_000_000;
  localparam int unsigned LongHold   = 300;
  localparam int unsigned StepCap    = 24;

  typedef struct {
    cmd_e        cmd;
    logic [15:0] px, py, qx, qy, scalar;
  } ec_item_t;

  typedef struct {
    logic [15:0] rx, ry;
    logic        inf;
    logic [15:0] mult;
  } ec_res_t;

  typedef struct {
    bit [31:0] x, y;
    bit        inf;
  } ec_pt_t;

  typedef struct {
    ec_item_t item;
    bit       typed;
    ec_res_t  want;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;
  logic        cfg_we_i;
  logic [CfgIdxBits-1:0] cfg_idx_i;
  logic [15:0] cfg_wdata_i;

  ec_point_add_double_scalar_mult dut (.*);

  bit [15:0]   prime_cfg = 16'd97;
  bit [15:0]   a_cfg = 16'd2;
  ec_res_t     result_q[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit          quiet = 0;
  bit          hold_req = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic bit [31:0] fadd(bit [31:0] a, bit [31:0] b, bit [31:0] p);
    return (a >= p - b) ? a - (p - b) : a + b;
  endfunction

  function automatic bit [31:0] fsub(bit [31:0] a, bit [31:0] b, bit [31:0] p);
    return (a >= b) ? a - b : p - (b - a);
  endfunction

  function automatic bit [31:0] fmul(bit [31:0] a, bit [31:0] b, bit [31:0] p);
    bit [31:0] r;
    r = 0;
    while (b != 0) begin
      if (b[0]) r = fadd(r, a, p);
      a = fadd(a, a, p);
      b = b >> 1;
    end
    return r;
  endfunction

  function automatic bit finv(bit [31:0] v, bit [31:0] p, output bit [31:0] inv);
    bit [31:0] r0, r1, r2, t0, t1, t2, q;
    r0 = p;
    r1 = v % p;
    t0 = 0;
    t1 = 1;
    inv = 0;
    while (r1 != 0) begin
      q  = r0 / r1;
      r2 = r0 - q * r1;
      t2 = fsub(t0, fmul(q % p, t1, p), p);
      r0 = r1; r1 = r2; t0 = t1; t1 = t2;
    end
    if (r0 != 1) return 0;
    inv = t0;
    return 1;
  endfunction

  function automatic ec_pt_t on_slope(bit [31:0] l, bit [31:0] x1, bit [31:0] y1,
                                      bit [31:0] x2, bit [31:0] p);
    ec_pt_t r;
    r.x = fsub(fsub(fmul(l, l, p), x1, p), x2, p);
    r.y = fsub(fmul(l, fsub(x1, r.x, p), p), y1, p);
    r.inf = 0;
    return r;
  endfunction

  function automatic ec_pt_t pt_dbl(ec_pt_t a, bit [31:0] ca, bit [31:0] p);
    ec_pt_t    r;
    bit [31:0] inv, num;
    r = '{0, 0, 1};
    if (a.inf || a.y == 0) return r;
    if (!finv(fadd(a.y, a.y, p), p, inv)) return r;
    num = fadd(fmul(3, fmul(a.x, a.x, p), p), ca, p);
    return on_slope(fmul(num, inv, p), a.x, a.y, a.x, p);
  endfunction

  function automatic ec_pt_t pt_sum(ec_pt_t a, ec_pt_t b, bit [31:0] ca, bit [31:0] p);
    ec_pt_t    r;
    bit [31:0] inv;
    r = '{0, 0, 1};
    if (a.inf) return b;
    if (b.inf) return a;
    if (a.x == b.x) begin
      if (a.y == b.y) return pt_dbl(a, ca, p);
      return r;
    end
    if (!finv(fsub(b.x, a.x, p), p, inv)) return r;
    return on_slope(fmul(fsub(b.y, a.y, p), inv, p), a.x, a.y, b.x, p);
  endfunction

  // Returns 0 when a scalar multiply would have to go past the multiple cap.
  function automatic bit point_result(ec_item_t it, int unsigned cap, output ec_res_t res);
    bit [31:0] p, ca, m, mult;
    ec_pt_t    pp, qq, rr;
    p = (prime_cfg < 3) ? 32'd3 : 32'(prime_cfg);
    ca = a_cfg % p;
    pp = '{it.px % p, it.py % p, 0};
    qq = '{it.qx % p, it.qy % p, 0};
    res = '{16'd0, 16'd0, 1'b1, 16'd0};
    case (it.cmd)
      CMD_NOP: return 1;
      CMD_ADD: begin
        rr = pt_sum(pp, qq, ca, p);
        mult = 1;
      end
      CMD_DBL: begin
        rr = pt_dbl(pp, ca, p);
        mult = 2;
      end
      default: begin
        m = (it.scalar < 2) ? 32'd2 : 32'(it.scalar);
        mult = 2;
        rr = pt_dbl(pp, ca, p);
        while (!rr.inf && mult != m) begin
          if (mult >= cap) return 0;
          mult++;
          rr = pt_sum(pp, rr, ca, p);
        end
      end
    endcase
    if (rr.inf) begin
      rr.x = 0;
      rr.y = 0;
    end
    res = '{rr.x[15:0], rr.y[15:0], rr.inf, mult[15:0]};
    return 1;
  endfunction

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch in %s: got %0h, expected %0h", what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    ec_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (result_q.size() == 0) begin
        $display("result beat with nothing expected: %h", m_axis_tdata);
        errors++;
      end else begin
        want = result_q.pop_front();
        if (m_axis_tdata[15:0] !== want.rx) report("rx", m_axis_tdata[15:0], want.rx);
        if (m_axis_tdata[31:16] !== want.ry) report("ry", m_axis_tdata[31:16], want.ry);
        if (m_axis_tdata[32] !== want.inf) report("at_infinity", m_axis_tdata[32], want.inf);
        if (m_axis_tdata[48:33] !== want.mult)
          report("multiple_reached", m_axis_tdata[48:33], want.mult);
      end
    end
  end

  initial begin
    int unsigned burst, held;
    bit          hold_done;
    burst = 0;
    held = 0;
    hold_done = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        m_axis_tready = 1'b0;
        held++;
        if (held >= LongHold) hold_done = 1;
      end else if (quiet) begin
        m_axis_tready = 1'b1;
      end else if (burst > 0) begin
        m_axis_tready = 1'b0;
        burst--;
      end else if ($urandom_range(0, 5) == 0) begin
        m_axis_tready = 1'b0;
        burst = $urandom_range(0, 3);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic offer(ec_item_t it, bit typed, ec_res_t want);
    ec_res_t res;
    bit      ok;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {6'd0, it.scalar, it.qy, it.qx, it.py, it.px, it.cmd};
    while (!s_axis_tready) @(negedge clk_i);
    ok = point_result(it, 32'h2_0000, res);
    result_q.push_back(typed ? want : res);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (result_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [15:0] value);
    drain();
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == REG_PRIME) prime_cfg = value;
    else a_cfg = value;
  endtask

  function automatic ec_item_t random_item();
    ec_item_t it;
    ec_res_t  res;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    it.cmd = (pick < 4) ? CMD_MUL : (pick < 6) ? CMD_ADD : (pick < 9) ? CMD_DBL : CMD_NOP;
    if ($urandom_range(0, 1)) begin
      it.px = $urandom;
      it.py = $urandom;
    end else begin
      it.px = $urandom_range(0, 20);
      it.py = $urandom_range(0, 20);
    end
    case ($urandom_range(0, 3))
      0: begin it.qx = it.px; it.qy = it.py; end
      1: begin it.qx = it.px + prime_cfg; it.qy = $urandom; end
      default: begin it.qx = $urandom; it.qy = $urandom; end
    endcase
    it.scalar = $urandom;
    if (!point_result(it, StepCap, res)) it.scalar = $urandom_range(0, 8);
    return it;
  endfunction

  initial begin
    dir_row_t    rows[$];
    ec_res_t     none;
    logic [15:0] primes[6];
    logic [15:0] coeffs[6];
    none = '{16'd0, 16'd0, 1'b0, 16'd0};
    primes = '{16'd97, 16'd3, 16'd65521, 16'd1, 16'd91, 16'd65535};
    coeffs = '{16'd2, 16'd0, 16'd65520, 16'd5, 16'd7, 16'd65535};

    rows.push_back('{'{CMD_NOP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1,
                     '{16'd0, 16'd0, 1'b1, 16'd0}});
    rows.push_back('{'{CMD_DBL, 16'd5, 16'd0, 16'd0, 16'd0, 16'd0}, 1,
                     '{16'd0, 16'd0, 1'b1, 16'd2}});
    rows.push_back('{'{CMD_ADD, 16'd3, 16'd6, 16'd3, 16'd10, 16'd0}, 1,
                     '{16'd0, 16'd0, 1'b1, 16'd1}});
    rows.push_back('{'{CMD_DBL, 16'd97, 16'd194, 16'd0, 16'd0, 16'd0}, 1,
                     '{16'd0, 16'd0, 1'b1, 16'd2}});
    rows.push_back('{'{CMD_ADD, 16'd3, 16'd6, 16'd3, 16'd6, 16'd0}, 0, none});
    rows.push_back('{'{CMD_ADD, 16'd3, 16'd6, 16'd80, 16'd10, 16'd0}, 0, none});
    rows.push_back('{'{CMD_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 0, none});
    rows.push_back('{'{CMD_ADD, 16'd0, 16'd0, 16'd1, 16'd96, 16'd0}, 0, none});
    rows.push_back('{'{CMD_DBL, 16'd3, 16'd6, 16'd0, 16'd0, 16'd0}, 0, none});
    rows.push_back('{'{CMD_DBL, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0}, 0, none});
    rows.push_back('{'{CMD_MUL, 16'd3, 16'd6, 16'd0, 16'd0, 16'd0}, 0, none});
    rows.push_back('{'{CMD_MUL, 16'd3, 16'd6, 16'd0, 16'd0, 16'd1}, 0, none});
    rows.push_back('{'{CMD_MUL, 16'd3, 16'd6, 16'd0, 16'd0, 16'd2}, 0, none});
    rows.push_back('{'{CMD_MUL, 16'd3, 16'd6, 16'd0, 16'd0, 16'd5}, 0, none});
    rows.push_back('{'{CMD_MUL, 16'd3, 16'd6, 16'd0, 16'd0, 16'hFFFF}, 0, none});
    rows.push_back('{'{CMD_MUL, 16'd3, 16'd6, 16'hFFFF, 16'hFFFF, 16'h8000}, 0, none});
    rows.push_back('{'{CMD_MUL, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd2}, 0, none});

    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_PRIME;
    cfg_wdata_i = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) offer(rows[i].item, rows[i].typed, rows[i].want);

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_PRIME, primes[ph]);
      write_reg(REG_A, coeffs[ph]);
      if (ph == 5) quiet = 1;
      for (int n = 0; n < 15; n++) begin
        if (ph == 1 && n == 3) hold_req = 1;
        offer(random_item(), 0, none);
      end
    end

    drain();
    repeat (200) @(negedge clk_i);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
